/* rtl/ipdvc_pkg.sv */
// ----------------------------------------------------------------------------
// ipdvc_pkg
// shared types, register indexes and the saturation helper of the controller
// ----------------------------------------------------------------------------
package ipdvc_pkg;

  localparam int DataW = 16;
  localparam int AccW  = 32;
  localparam int WideW = 35;
  localparam int IdxW  = 3;

  // configuration register indexes
  localparam logic [IdxW-1:0] RegKp          = 3'd0;
  localparam logic [IdxW-1:0] RegKiTs        = 3'd1;
  localparam logic [IdxW-1:0] RegOutputLimit = 3'd2;
  localparam logic [IdxW-1:0] RegAutoWindup  = 3'd3;
  localparam logic [IdxW-1:0] RegUseBackward = 3'd4;

  localparam logic signed [WideW-1:0] AccMax = 35'sd2147483647;
  localparam logic signed [WideW-1:0] AccMin = -35'sd2147483648;

  typedef struct packed {
    logic signed [15:0] kp;
    logic [15:0]        ki_ts;
    logic [14:0]        output_limit;
    logic               auto_windup;
    logic               use_backward;
  } cfg_t;

  // rounded terms of one sample, ready for the accumulator update
  typedef struct packed {
    logic signed [24:0] p_term;
    logic signed [16:0] i_term;
    logic signed [16:0] dff;
    logic signed [15:0] error;
    logic               ext_windup;
  } prod_t;

  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [WideW-1:0] v);
    logic signed [AccW-1:0] r;
    if (v > AccMax) begin
      r = AccMax[AccW-1:0];
    end else if (v < AccMin) begin
      r = AccMin[AccW-1:0];
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/ipdvc_prep.sv */
// ----------------------------------------------------------------------------
// ipdvc_prep
// input register, gain products with rounding and sample differences
// ----------------------------------------------------------------------------
module ipdvc_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                adv,
  input  logic [47:0]         in_data,
  input  logic                in_ext,
  input  ipdvc_pkg::cfg_t     cfg,
  output ipdvc_pkg::prod_t    prod
);

  logic signed [15:0] error;
  logic signed [15:0] measured;
  logic signed [15:0] feedforward;
  logic               ext_windup;
  logic signed [15:0] previous_measured;
  logic signed [15:0] previous_feedforward;

  logic signed [16:0] dmeas;
  logic signed [16:0] dff;
  logic signed [32:0] kp_ext;
  logic signed [32:0] dmeas_ext;
  logic signed [32:0] p_prod;
  logic signed [32:0] p_round;
  logic signed [32:0] ki_ext;
  logic signed [32:0] err_ext;
  logic signed [32:0] i_prod;
  logic signed [32:0] i_round;

  always_ff @(posedge clk) begin
    if (load) begin
      error       <= in_data[15:0];
      measured    <= in_data[31:16];
      feedforward <= in_data[47:32];
      ext_windup  <= in_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_measured    <= '0;
      previous_feedforward <= '0;
    end else if (adv) begin
      previous_measured    <= measured;
      previous_feedforward <= feedforward;
    end
  end

  assign dmeas = 17'(measured) - 17'(previous_measured);
  assign dff   = 17'(feedforward) - 17'(previous_feedforward);

  // kp * dmeas rounded half up to whole units, q8.8 gain
  assign kp_ext    = 33'(cfg.kp);
  assign dmeas_ext = 33'(dmeas);
  assign p_prod    = kp_ext * dmeas_ext;
  assign p_round   = p_prod + 33'sd128;

  // ki_ts * error rounded half up, q0.16 gain
  assign ki_ext  = $signed({17'b0, cfg.ki_ts});
  assign err_ext = 33'(error);
  assign i_prod  = ki_ext * err_ext;
  assign i_round = i_prod + 33'sd32768;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod.p_term     <= p_round[32:8];
      prod.i_term     <= i_round[32:16];
      prod.dff        <= dff;
      prod.error      <= error;
      prod.ext_windup <= ext_windup;
    end
  end

endmodule

/* rtl/ipdvc_core.sv */
// ----------------------------------------------------------------------------
// ipdvc_core
// windup test, accumulator update, output clamp and result register
// ----------------------------------------------------------------------------
module ipdvc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  ipdvc_pkg::cfg_t     cfg,
  input  ipdvc_pkg::prod_t    prod,
  output logic [15:0]         drive,
  output logic                windup_active
);

  logic signed [31:0] accumulator;
  logic signed [15:0] last_output;
  logic signed [15:0] tracked_output;
  logic signed [31:0] last_integral_step;

  logic signed [31:0] accumulator_next;
  logic signed [15:0] tracked_output_next;
  logic signed [31:0] last_integral_step_next;
  logic signed [15:0] drive_next;
  logic               windup;

  logic signed [34:0] d_val;
  logic signed [34:0] t_wide;
  logic signed [31:0] acc1;
  logic signed [31:0] acc2;
  logic signed [31:0] acc3;
  logic signed [31:0] lim;
  logic               err_match;

  always_comb begin
    // error and last output both nonzero with the same sign
    err_match = ((prod.error > 0) && (last_output > 0)) ||
                ((prod.error < 0) && (last_output < 0));
    if (cfg.auto_windup) begin
      tracked_output_next = last_output;
      windup = (accumulator != 32'(last_output)) && err_match;
    end else begin
      tracked_output_next = tracked_output;
      windup = prod.ext_windup && err_match;
    end

    // backward recalculation of the last integral step
    t_wide = 35'(tracked_output_next);
    d_val  = t_wide - 35'(accumulator) + 35'(last_integral_step);
    acc1   = accumulator;
    if ((last_integral_step != 0) && windup && cfg.use_backward) begin
      if ((d_val == 0) || (t_wide == 0) || ((d_val > 0) && (t_wide > 0)) ||
          ((d_val < 0) && (t_wide < 0))) begin
        // d and tracked output agree in sign: hold at the tracked output
        acc1 = 32'(tracked_output_next);
      end else begin
        acc1 = accumulator;
      end
      if ((d_val == 0) || (t_wide == 0) || ((d_val > 0) && (t_wide < 0)) ||
          ((d_val < 0) && (t_wide > 0))) begin
        acc1 = ipdvc_pkg::sat_acc(35'(accumulator) - 35'(last_integral_step));
      end
    end

    acc2 = ipdvc_pkg::sat_acc(35'(acc1) - 35'(prod.p_term));

    if (!windup) begin
      last_integral_step_next = 32'(prod.i_term);
      acc3 = ipdvc_pkg::sat_acc(35'(acc2) + 35'(prod.i_term));
    end else begin
      last_integral_step_next = '0;
      acc3 = acc2;
    end

    accumulator_next = ipdvc_pkg::sat_acc(35'(acc3) + 35'(prod.dff));

    lim = $signed({17'b0, cfg.output_limit});
    if (cfg.auto_windup) begin
      if (accumulator_next > lim) begin
        drive_next = $signed({1'b0, cfg.output_limit});
      end else if (accumulator_next < -lim) begin
        drive_next = -$signed({1'b0, cfg.output_limit});
      end else begin
        drive_next = accumulator_next[15:0];
      end
    end else begin
      if (accumulator_next > 32'sd32767) begin
        drive_next = 16'sh7FFF;
      end else if (accumulator_next < -32'sd32768) begin
        drive_next = 16'sh8000;
      end else begin
        drive_next = accumulator_next[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator        <= '0;
      last_output        <= '0;
      tracked_output     <= '0;
      last_integral_step <= '0;
    end else if (adv) begin
      accumulator        <= accumulator_next;
      last_output        <= drive_next;
      tracked_output     <= tracked_output_next;
      last_integral_step <= last_integral_step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive         <= drive_next;
      windup_active <= windup;
    end
  end

endmodule

/* rtl/ipd_velocity_controller_ff.sv */
// ----------------------------------------------------------------------------
// ipd_velocity_controller_ff
// incremental i-pd controller with feedforward and anti-windup
// ----------------------------------------------------------------------------
// Each input transfer carries one control sample and yields exactly one output
// transfer, once it has passed stage one, stage two and the result register. The
// block takes one sample per clock while the output side is not stalled: stage
// one registers the sample, stage two holds the rounded kp and ki_ts products
// with the sample differences, and the accumulator update (windup test, backward
// recalculation, proportional, integral and feedforward terms, each saturated to
// 32 bits) completes in one pass and loads the result register. That one-pass
// update loop on the accumulator sets the throughput of one sample per clock.
// Each stage moves on whenever the stage after it is empty or draining, so input
// transfers are still taken while a result waits on the output side, until both
// stages are full. Configuration writes go straight to the registers and must
// only be issued while no sample is in flight.
module ipd_velocity_controller_ff (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,    // error [15:0], measured [31:16], feedforward [47:32]
  input  logic        s_tuser,    // ext_windup
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // drive [15:0]
  output logic        m_tuser,    // windup_active
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ipdvc_pkg::cfg_t  cfg;
  ipdvc_pkg::prod_t prod;

  logic a_valid;
  logic b_valid;
  logic out_free;
  logic b_adv;
  logic b_free;
  logic a_adv;
  logic load;

  // configuration registers, writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp           <= '0;
      cfg.ki_ts        <= '0;
      cfg.output_limit <= 15'h7FFF;
      cfg.auto_windup  <= 1'b1;
      cfg.use_backward <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipdvc_pkg::RegKp:          cfg.kp           <= cfg_data;
        ipdvc_pkg::RegKiTs:        cfg.ki_ts        <= cfg_data;
        ipdvc_pkg::RegOutputLimit: cfg.output_limit <= cfg_data[14:0];
        ipdvc_pkg::RegAutoWindup:  cfg.auto_windup  <= cfg_data[0];
        ipdvc_pkg::RegUseBackward: cfg.use_backward <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage flow: each stage advances when the one after it can take the item
  assign out_free = !m_tvalid || m_tready;
  assign b_adv    = b_valid && out_free;
  assign b_free   = !b_valid || out_free;
  assign a_adv    = a_valid && b_free;
  assign s_tready = !a_valid || b_free;
  assign load     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        a_valid <= s_tvalid;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (out_free) begin
        m_tvalid <= b_valid;
      end
    end
  end

  // products and differences of the sample in stage one
  ipdvc_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .adv     (a_adv),
    .in_data (s_tdata),
    .in_ext  (s_tuser),
    .cfg     (cfg),
    .prod    (prod)
  );

  // accumulator state and result register
  ipdvc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .adv           (b_adv),
    .cfg           (cfg),
    .prod          (prod),
    .drive         (m_tdata),
    .windup_active (m_tuser)
  );

endmodule

/* bench/tb_ipd_velocity_controller_ff.sv */
// ----------------------------------------------------------------------------
// tb_ipd_velocity_controller_ff
// self-checking bench for the incremental i-pd controller with feedforward
// ----------------------------------------------------------------------------
// Control samples go in through the input stream and every result is checked
// against a cycle-free software copy of the controller kept in a scoreboard.
// A directed block hits windup, backward recalculation, clamping and the
// field extremes. Alternating kp steps then drive the accumulator into both
// 32-bit rails. Random phases with different gain settings and windup-prone
// error runs close the run. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [15:0] feedforward;
  logic signed [15:0] measured;
  logic signed [15:0] error;
  logic               ext_windup;
} sample_t;

typedef struct packed {
  logic signed [15:0] drive;
  logic               windup;
} ctrl_out_t;

class ctrl_scoreboard;
  longint kp, ki_ts, out_limit;
  bit     auto_windup, use_backward;
  longint acc, last_out, tracked, last_step, prev_ff, prev_meas;
  ctrl_out_t expected_out[$];
  int fail_count, results_checked, windup_count, samples_noted, reg_writes;

  function new();
    kp = 0;
    ki_ts = 0;
    out_limit = 32767;
    auto_windup = 1'b1;
    use_backward = 1'b0;
    acc = 0;
    last_out = 0;
    tracked = 0;
    last_step = 0;
    prev_ff = 0;
    prev_meas = 0;
    fail_count = 0;
    results_checked = 0;
    windup_count = 0;
    samples_noted = 0;
    reg_writes = 0;
  endfunction

  function longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function longint sat32(longint v);
    return clamp(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  // round half up, dropping the sh low fraction bits
  function longint round_shift(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function bit same_sign(longint a, longint b);
    return (a > 0 && b > 0) || (a < 0 && b < 0);
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] data);
    reg_writes++;
    case (idx)
      ipdvc_pkg::RegKp:          kp = longint'($signed(data));
      ipdvc_pkg::RegKiTs:        ki_ts = longint'(data);
      ipdvc_pkg::RegOutputLimit: out_limit = longint'(data[14:0]);
      ipdvc_pkg::RegAutoWindup:  auto_windup = data[0];
      ipdvc_pkg::RegUseBackward: use_backward = data[0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_out.size();
  endfunction

  // one accepted sample: advance the controller state and queue its output
  function void note_input(sample_t s);
    longint err, meas, ff, d, drive;
    bit wind;
    ctrl_out_t e;
    err = s.error;
    meas = s.measured;
    ff = s.feedforward;
    samples_noted++;

    if (auto_windup) begin
      tracked = last_out;
      wind = (acc != tracked) && same_sign(err, tracked);
    end else begin
      wind = s.ext_windup && same_sign(err, last_out);
    end

    // take back the last integral step, all of it or down to the tracked output
    if (last_step != 0 && wind && use_backward) begin
      d = tracked - acc + last_step;
      if (d == 0 || tracked == 0 || same_sign(d, -tracked)) begin
        acc = sat32(acc - last_step);
      end else begin
        acc = tracked;
      end
    end

    acc = sat32(acc - round_shift(kp * (meas - prev_meas), 8));
    if (!wind) begin
      last_step = round_shift(ki_ts * err, 16);
      acc = sat32(acc + last_step);
    end else begin
      last_step = 0;
    end
    acc = sat32(acc + (ff - prev_ff));

    if (auto_windup) begin
      drive = clamp(acc, -out_limit, out_limit);
    end else begin
      drive = clamp(acc, -32768, 32767);
    end
    last_out = drive;
    prev_ff = ff;
    prev_meas = meas;

    e.drive = drive[15:0];
    e.windup = wind;
    expected_out.push_back(e);
  endfunction

  function void check_result(logic [15:0] drive, logic windup);
    ctrl_out_t e;
    results_checked++;
    if (expected_out.size() == 0) begin
      $display("%0t: result with nothing outstanding, drive %0d windup %0b",
               $time, $signed(drive), windup);
      fail_count++;
      return;
    end
    e = expected_out.pop_front();
    if (e.windup) windup_count++;
    if (drive !== e.drive) begin
      $display("%0t: drive expected %0d got %0d", $time, e.drive, $signed(drive));
      fail_count++;
    end
    if (windup !== e.windup) begin
      $display("%0t: windup_active expected %0b got %0b", $time, e.windup, windup);
      fail_count++;
    end
  endfunction
endclass

module tb_ipd_velocity_controller_ff;

  // indexes past the last register, writes there must be dropped
  localparam logic [ipdvc_pkg::IdxW-1:0] RegSpareLo = 3'd5;
  localparam logic [ipdvc_pkg::IdxW-1:0] RegSpareHi = 3'd7;

  localparam int RandomPhases = 7;
  localparam int PhaseItems   = 105;
  localparam int DrillDown    = 270;   // about 256 full kp steps reach the low rail
  localparam int DrillUp      = 530;   // and about 512 climb to the high rail

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;     // error [15:0], measured [31:16], feedforward [47:32]
  logic        s_tuser = 1'b0;   // ext_windup
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;          // drive [15:0]
  logic        m_tuser;          // windup_active
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int send_idle_pct = 21;
  int recv_stall_pct = 21;

  // running levels and sign runs for the random samples
  int meas_level = 0;
  int ff_level = 0;
  int run_left = 0;
  bit run_neg = 1'b0;

  ctrl_scoreboard sb;

  always #10 clk = ~clk;

  ipd_velocity_controller_ff dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // output side: values seen here are the ones the block saw at this edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser);
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // guard against a hung handshake
  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

  // call at a rising edge; returns at the edge where the transfer happened
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {s.feedforward, s.measured, s.error};
    s_tuser  <= s.ext_windup;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(s);
  endtask

  task automatic send_fields(input logic [15:0] err, input logic [15:0] meas,
                             input logic [15:0] ff, input logic ext);
    sample_t s;
    s.error = err;
    s.measured = meas;
    s.feedforward = ff;
    s.ext_windup = ext;
    send_sample(s);
  endtask

  // stop sending and wait until every result is back and the pipe is empty
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_config(input logic [15:0] kp_v, input logic [15:0] ki_v,
                              input logic [14:0] lim_v, input bit aw, input bit bw,
                              input bit spare);
    set_reg(ipdvc_pkg::RegKp, kp_v);
    set_reg(ipdvc_pkg::RegKiTs, ki_v);
    set_reg(ipdvc_pkg::RegOutputLimit, {1'b0, lim_v});
    set_reg(ipdvc_pkg::RegAutoWindup, {15'd0, aw});
    set_reg(ipdvc_pkg::RegUseBackward, {15'd0, bw});
    if (spare) begin
      set_reg(RegSpareLo, 16'($urandom));
      set_reg(RegSpareHi, 16'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  // full-scale measurement swings with kp flipped between them, so every
  // sample moves the accumulator the same way by about 2^23
  task automatic kp_drill(input int count, input bit upward);
    logic [15:0] k;
    for (int i = 0; i < count; i++) begin
      drain();
      k = (((i % 2) == 0) ^ upward) ? 16'h7FFF : 16'h8000;
      set_reg(ipdvc_pkg::RegKp, k);
      cfg_we <= 1'b0;
      send_fields(16'($urandom), ((i % 2) == 0) ? 16'h7FFF : 16'h8000,
                  16'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  function automatic int clip16(int v);
    return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
  endfunction

  // mostly runs of same-signed error on a slowly moving plant, which is what
  // pushes the output into the limit and brings up windup; the rest is noise
  function automatic sample_t next_sample();
    sample_t s;
    int r, mag;
    r = int'($urandom_range(99));
    if (run_left == 0) begin
      run_left = int'($urandom_range(20, 4));
      run_neg = 1'($urandom_range(1));
    end
    run_left--;
    meas_level = clip16(meas_level + int'($urandom_range(64)) - 32);
    ff_level = clip16(ff_level + int'($urandom_range(32)) - 16);
    if (r < 55) begin
      mag = ($urandom_range(3) == 0) ? int'($urandom_range(16, 1)) :
                                       int'($urandom_range(32767, 1));
      s.error = 16'(run_neg ? -mag : mag);
      s.measured = 16'(meas_level);
      s.feedforward = 16'(ff_level);
      s.ext_windup = ($urandom_range(99) < 80);
    end else if (r < 75) begin
      s = 49'({$urandom, $urandom});
    end else if (r < 90) begin
      s.error = 16'(int'($urandom_range(8)) - 4);
      s.measured = 16'(clip16(meas_level + int'($urandom_range(4)) - 2));
      s.feedforward = 16'(ff_level);
      s.ext_windup = 1'($urandom_range(1));
    end else begin
      s.error = pick_extreme();
      s.measured = pick_extreme();
      s.feedforward = pick_extreme();
      s.ext_windup = 1'($urandom_range(1));
    end
    return s;
  endfunction

  initial begin
    logic [15:0] kp_v, ki_v;
    logic [14:0] lim_v;
    int pause_at;

    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unity kp, full ki, tight limit, automatic windup with backward steps
    apply_config(16'h0100, 16'hFFFF, 15'd1000, 1'b1, 1'b1, 1'b0);
    send_fields(16'h7FFF, 16'h0000, 16'h0000, 1'b0);  // integrate past the limit
    send_fields(16'h7FFF, 16'h0000, 16'h0000, 1'b0);  // windup, snap back to output
    send_fields(16'h8000, 16'h0000, 16'h0000, 1'b0);  // opposite sign releases it
    send_fields(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    send_fields(16'h0000, 16'h0000, 16'h7FFF, 1'b0);  // feedforward step only
    send_fields(16'h0001, 16'h0000, 16'h7FFF, 1'b0);  // windup, integration held
    send_fields(16'h0010, 16'h0000, 16'h7FFF, 1'b0);  // windup again, no integral step left to remove
    send_fields(16'h0010, 16'h7FFF, 16'h8000, 1'b0);
    send_fields(16'hFFF0, 16'h8000, 16'h7FFF, 1'b1);
    drain();

    // zero limit pins the output at zero whatever the proportional kick
    apply_config(16'h8000, 16'h0000, 15'd0, 1'b1, 1'b0, 1'b0);
    send_fields(16'h0000, 16'h7FFF, 16'h0000, 1'b0);
    send_fields(16'h0000, 16'h8000, 16'h0000, 1'b0);
    send_fields(16'h0005, 16'h0000, 16'h0000, 1'b0);
    drain();

    // manual windup from the external flag, 16-bit output saturation
    apply_config(16'h7FFF, 16'h8000, 15'h7FFF, 1'b0, 1'b1, 1'b1);
    send_fields(16'h7FFF, 16'h8000, 16'h8000, 1'b1);
    send_fields(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_fields(16'h8000, 16'h8000, 16'h0000, 1'b1);
    send_fields(16'h8000, 16'h0000, 16'h0000, 1'b0);
    send_fields(16'h0064, 16'h0000, 16'h0000, 1'b1);
    send_fields(16'hFF9C, 16'h0000, 16'h0000, 1'b1);
    drain();

    // accumulator into the low rail and then the high rail
    apply_config(16'h0000, 16'h0000, 15'h7FFF, 1'b0, 1'b0, 1'b0);
    send_fields(16'($urandom), 16'h8000, 16'h0000, 1'b0);
    kp_drill(DrillDown, 1'b0);
    kp_drill(DrillUp, 1'b1);

    for (int p = 0; p < RandomPhases; p++) begin
      drain();
      case (p % 3)
        0:       kp_v = pick_extreme();
        1:       kp_v = 16'(int'($urandom_range(1024)) - 512);
        default: kp_v = 16'($urandom);
      endcase
      ki_v = (p == 1) ? 16'hFFFF : ((p == 4) ? 16'h0000 : 16'($urandom));
      if (p == 2) begin
        lim_v = 15'd0;
      end else if (p == 5) begin
        lim_v = 15'h7FFF;
      end else if (p % 2 == 1) begin
        lim_v = 15'($urandom_range(2000));
      end else begin
        lim_v = 15'($urandom_range(32767));
      end
      apply_config(kp_v, ki_v, lim_v, 1'(p % 2), 1'((p / 2) % 2), p == 6);

      // one phase runs with both sides always ready
      send_idle_pct = (p == 3) ? 0 : 21;
      recv_stall_pct = (p == 3) ? 0 : 21;
      pause_at = int'($urandom_range(PhaseItems - 10, 10));
      for (int i = 0; i < PhaseItems; i++) begin
        if (i == pause_at) drain();
        send_sample(next_sample());
      end
    end

    drain();
    repeat (8) @(posedge clk);

    $display("sent %0d samples, checked %0d results, %0d of them with integration held",
             sb.samples_noted, sb.results_checked, sb.windup_count);
    $display("%0d register writes across directed, rail-to-rail and %0d random phases",
             sb.reg_writes, RandomPhases);
    if (sb.fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ipdvc_pkg.sv
rtl/ipdvc_prep.sv
rtl/ipdvc_core.sv
rtl/ipd_velocity_controller_ff.sv
bench/tb_ipd_velocity_controller_ff.sv
